>>> sv/assert_macros.svh
// assertion macros used by the channel activity ranker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define CAR_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define CAR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/car_pkg.sv
// types, constants and codes of the channel activity ranker
package car_pkg;

   localparam int CHANNELS    = 16;
   localparam int TOP_SLOTS   = 4;
   localparam int RANK_FIELDS = 4;
   localparam int FILL_SLOTS  = (TOP_SLOTS < RANK_FIELDS) ? TOP_SLOTS : RANK_FIELDS;
   localparam int CH_W        = $clog2(CHANNELS);

   typedef logic [CH_W-1:0] ch_idx_type;
   typedef logic [23:0]     act_type;
   typedef logic [31:0]     word_type;
   typedef logic [4:0]      rank_type;
   typedef logic [1:0]      slot_type;

   localparam act_type  ACT_ONE    = 24'h010000;
   localparam act_type  ACT_MAX    = 24'hFFFFFF;
   localparam rank_type EMPTY_RANK = 5'h1F;

   // item kinds carried on tuser
   typedef enum logic [1:0] {
      REQ_EVENT = 2'd0,
      REQ_DRAIN = 2'd1,
      REQ_DECAY = 2'd2
   } req_kind_type;

   // register indexes (byte address divided by four)
   typedef enum logic [2:0] {
      REG_DISPLAY_MODE   = 3'd0,
      REG_DECAY_FACTOR   = 3'd1,
      REG_ACTIVITY_FLOOR = 3'd2,
      REG_IDLE_MS        = 3'd3,
      REG_DRAIN_MS       = 3'd4
   } reg_idx_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVENT,
      ST_DRAIN_CHK,
      ST_DRAIN_CH,
      ST_DRAIN_TOT,
      ST_DECAY_MUL,
      ST_DECAY_WR,
      ST_RANK_SCAN,
      ST_RANK_PICK,
      ST_DONE
   } state_type;

endpackage

>>> sv/channel_activity_ranker.sv
// channel activity ranker: per-channel activity state, drain, decay and top-four ranking
//
// Input items arrive on req_ (tuser: item kind, tdata: channel and time in ms).
// An event adds 1.0 of activity to its channel and bumps its count and the
// total; a drain tick ages idle counts; a decay frame scales every activity.
// Each item returns one result on rsp_ with the top four channels, how many
// slots hold a channel and the running total.
// The block works on one item at a time: req_tready is high only while idle.
// After accept an event updates its channel, a drain tick that is due ages each
// channel and then the total, a decay frame multiplies and writes each channel
// in turn, and an unused kind goes straight on; all then rank, and the ranking
// ends at the first slot that finds no channel. req_tready returns high in the
// cycle after the result is loaded. The single compare unit sweeps all channels
// once per rank slot. The result sits in an output register; if that still holds
// an earlier result and rsp_tready is low, the sequencer holds its finished result
// until the register frees up, and stays not ready. Reset clears all channel state,
// counts and times and loads register defaults. Registers on csr_ are to be written
// only while the block is idle; the block itself does not enforce this.
`include "assert_macros.svh"

module channel_activity_ranker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // channel [3:0], now_ms [35:4], zero fill
   input  logic [1:0]  req_tuser,   // req_type [1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // rank_first [4:0], rank_second [9:5],
                                    // rank_third [14:10], rank_fourth [19:15],
                                    // ranked_count [22:20], total_events [54:23]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam car_pkg::ch_idx_type LAST_CH   = car_pkg::ch_idx_type'(car_pkg::CHANNELS - 1);
   localparam car_pkg::slot_type   LAST_SLOT = car_pkg::slot_type'(car_pkg::FILL_SLOTS - 1);

   // configuration registers
   logic        display_mode_ff;
   logic [15:0] decay_factor_ff;
   logic [15:0] activity_floor_ff;
   logic [19:0] idle_ms_ff;
   logic [16:0] drain_ms_ff;

   // captured item
   logic                chan_ok_ff;
   car_pkg::word_type   now_ff;

   // channel state
   car_pkg::act_type    act_ff  [car_pkg::CHANNELS];
   car_pkg::word_type   cnt_ff  [car_pkg::CHANNELS];
   car_pkg::word_type   stamp_ff[car_pkg::CHANNELS];
   car_pkg::word_type   total_ff;
   car_pkg::word_type   last_any_ff;
   car_pkg::word_type   last_drain_ff;

   // sequencer
   car_pkg::state_type  state_ff, state_in;
   car_pkg::ch_idx_type idx_ff;
   car_pkg::slot_type   slot_ff;
   logic                found_ff;
   logic [car_pkg::CHANNELS-1:0] taken_ff;
   logic [2:0]          ranked_n_ff;
   car_pkg::ch_idx_type best_ff;
   car_pkg::act_type    best_act_ff;
   car_pkg::word_type   best_cnt_ff;
   car_pkg::rank_type   rank_ff[car_pkg::RANK_FIELDS];
   car_pkg::act_type    prod_ff;

   // output register
   logic                rsp_valid_ff;
   logic [55:0]         rsp_data_ff;

   logic                req_acc;
   logic                csr_wr;
   logic [2:0]          reg_sel;
   logic                out_free;
   car_pkg::act_type    cur_act;
   car_pkg::word_type   cur_cnt;
   car_pkg::word_type   stamp_sel;
   car_pkg::word_type   limit_sel;
   car_pkg::word_type   elapsed;
   logic                elapsed_ge;
   logic [24:0]         act_sum;
   logic [39:0]         product;
   logic                eligible;
   logic                better;

   assign req_acc    = req_tvalid & req_tready;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign reg_sel    = csr_paddr[4:2];
   assign csr_pready = 1'b1;
   assign out_free   = ~rsp_valid_ff | rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         display_mode_ff   <= 1'b0;
         decay_factor_ff   <= 16'd65506;
         activity_floor_ff <= 16'd131;
         idle_ms_ff        <= 20'd20000;
         drain_ms_ff       <= 17'd250;
      end else if (csr_wr) begin
         unique case (reg_sel)
            car_pkg::REG_DISPLAY_MODE:   display_mode_ff   <= csr_pwdata[0];
            car_pkg::REG_DECAY_FACTOR:   decay_factor_ff   <= csr_pwdata[15:0];
            car_pkg::REG_ACTIVITY_FLOOR: activity_floor_ff <= csr_pwdata[15:0];
            car_pkg::REG_IDLE_MS:        idle_ms_ff        <= csr_pwdata[19:0];
            car_pkg::REG_DRAIN_MS:       drain_ms_ff       <= csr_pwdata[16:0];
            default: ;
         endcase
      end
   end

   // register reads
   always_comb begin
      unique case (reg_sel)
         car_pkg::REG_DISPLAY_MODE:   csr_prdata = {31'd0, display_mode_ff};
         car_pkg::REG_DECAY_FACTOR:   csr_prdata = {16'd0, decay_factor_ff};
         car_pkg::REG_ACTIVITY_FLOOR: csr_prdata = {16'd0, activity_floor_ff};
         car_pkg::REG_IDLE_MS:        csr_prdata = {12'd0, idle_ms_ff};
         car_pkg::REG_DRAIN_MS:       csr_prdata = {15'd0, drain_ms_ff};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   // item capture
   always_ff @(posedge clock) begin
      if (req_acc) begin
         chan_ok_ff  <= ({28'd0, req_tdata[3:0]} < 32'(car_pkg::CHANNELS));
         now_ff      <= req_tdata[35:4];
      end
   end

   // entry at the sweep index
   assign cur_act = act_ff[idx_ff];
   assign cur_cnt = cnt_ff[idx_ff];

   // shared elapsed-time unit: one subtract and one compare
   always_comb begin
      unique case (state_ff)
         car_pkg::ST_DRAIN_CHK: begin
            stamp_sel = last_drain_ff;
            limit_sel = {15'd0, drain_ms_ff};
         end
         car_pkg::ST_DRAIN_CH: begin
            stamp_sel = stamp_ff[idx_ff];
            limit_sel = {12'd0, idle_ms_ff};
         end
         default: begin
            stamp_sel = last_any_ff;
            limit_sel = {12'd0, idle_ms_ff};
         end
      endcase
   end
   assign elapsed    = now_ff - stamp_sel;
   assign elapsed_ge = (elapsed >= limit_sel);

   // event add and decay multiply
   assign act_sum = {1'b0, cur_act} + {1'b0, car_pkg::ACT_ONE};
   assign product = 40'(cur_act) * 40'(decay_factor_ff);

   // rank compare unit
   assign eligible = ~taken_ff[idx_ff] &
                     (display_mode_ff ? (cur_act != '0) : (cur_cnt != '0));
   assign better   = eligible &
                     (~found_ff | (cur_act > best_act_ff) |
                      (~display_mode_ff & (cur_act == best_act_ff) & (cur_cnt > best_cnt_ff)));

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= car_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and handshake
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      unique case (state_ff)
         car_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               unique case (req_tuser)
                  car_pkg::REQ_EVENT: state_in = car_pkg::ST_EVENT;
                  car_pkg::REQ_DRAIN: state_in = car_pkg::ST_DRAIN_CHK;
                  car_pkg::REQ_DECAY: state_in = car_pkg::ST_DECAY_MUL;
                  default:            state_in = car_pkg::ST_RANK_SCAN;
               endcase
            end
         end
         car_pkg::ST_EVENT:     state_in = car_pkg::ST_RANK_SCAN;
         car_pkg::ST_DRAIN_CHK: state_in = elapsed_ge ? car_pkg::ST_DRAIN_CH
                                                      : car_pkg::ST_RANK_SCAN;
         car_pkg::ST_DRAIN_CH: begin
            if (idx_ff == LAST_CH) state_in = car_pkg::ST_DRAIN_TOT;
         end
         car_pkg::ST_DRAIN_TOT: state_in = car_pkg::ST_RANK_SCAN;
         car_pkg::ST_DECAY_MUL: state_in = car_pkg::ST_DECAY_WR;
         car_pkg::ST_DECAY_WR: begin
            state_in = (idx_ff == LAST_CH) ? car_pkg::ST_RANK_SCAN : car_pkg::ST_DECAY_MUL;
         end
         car_pkg::ST_RANK_SCAN: begin
            if (idx_ff == LAST_CH) state_in = car_pkg::ST_RANK_PICK;
         end
         car_pkg::ST_RANK_PICK: begin
            state_in = (~found_ff || slot_ff == LAST_SLOT) ? car_pkg::ST_DONE
                                                          : car_pkg::ST_RANK_SCAN;
         end
         car_pkg::ST_DONE: begin
            if (out_free) state_in = car_pkg::ST_IDLE;
         end
      endcase
   end

   // channel state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < car_pkg::CHANNELS; c++) begin
            act_ff[c]   <= '0;
            cnt_ff[c]   <= '0;
            stamp_ff[c] <= '0;
         end
         total_ff      <= '0;
         last_any_ff   <= '0;
         last_drain_ff <= '0;
      end else begin
         unique case (state_ff)
            car_pkg::ST_EVENT: begin
               if (chan_ok_ff) begin
                  act_ff[idx_ff]   <= act_sum[24] ? car_pkg::ACT_MAX : act_sum[23:0];
                  if (cur_cnt != '1) cnt_ff[idx_ff] <= cur_cnt + 32'd1;
                  stamp_ff[idx_ff] <= now_ff;
                  if (total_ff != '1) total_ff <= total_ff + 32'd1;
                  last_any_ff      <= now_ff;
               end
            end
            car_pkg::ST_DRAIN_CHK: begin
               if (elapsed_ge) last_drain_ff <= now_ff;
            end
            car_pkg::ST_DRAIN_CH: begin
               if (cur_cnt != '0 && elapsed_ge) cnt_ff[idx_ff] <= cur_cnt - 32'd1;
            end
            car_pkg::ST_DRAIN_TOT: begin
               if (total_ff != '0 && elapsed_ge) total_ff <= total_ff - 32'd1;
            end
            car_pkg::ST_DECAY_WR: begin
               act_ff[idx_ff] <= (prod_ff < {8'd0, activity_floor_ff}) ? '0 : prod_ff;
            end
            default: ;
         endcase
      end
   end

   // decay product register
   always_ff @(posedge clock) begin
      if (state_ff == car_pkg::ST_DECAY_MUL) prod_ff <= product[39:16];
   end

   // sweep index, slot and rank control
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff      <= '0;
         slot_ff     <= '0;
         found_ff    <= 1'b0;
         taken_ff    <= '0;
         ranked_n_ff <= '0;
      end else begin
         unique case (state_ff)
            car_pkg::ST_IDLE: begin
               if (req_acc) begin
                  idx_ff      <= (req_tuser == car_pkg::REQ_EVENT)
                                 ? car_pkg::ch_idx_type'(req_tdata[3:0]) : '0;
                  slot_ff     <= '0;
                  found_ff    <= 1'b0;
                  taken_ff    <= '0;
                  ranked_n_ff <= '0;
               end
            end
            car_pkg::ST_EVENT: idx_ff <= '0;
            car_pkg::ST_DRAIN_CH, car_pkg::ST_DECAY_WR: begin
               idx_ff <= (idx_ff == LAST_CH) ? '0 : idx_ff + 1'b1;
            end
            car_pkg::ST_RANK_SCAN: begin
               idx_ff <= (idx_ff == LAST_CH) ? '0 : idx_ff + 1'b1;
               if (better) found_ff <= 1'b1;
            end
            car_pkg::ST_RANK_PICK: begin
               if (found_ff) begin
                  taken_ff[best_ff] <= 1'b1;
                  ranked_n_ff       <= ranked_n_ff + 3'd1;
               end
               slot_ff  <= slot_ff + 1'b1;
               found_ff <= 1'b0;
            end
            default: ;
         endcase
      end
   end

   // best candidate and rank slots
   always_ff @(posedge clock) begin
      if (state_ff == car_pkg::ST_IDLE && req_acc) begin
         for (int s = 0; s < car_pkg::RANK_FIELDS; s++) rank_ff[s] <= car_pkg::EMPTY_RANK;
      end
      if (state_ff == car_pkg::ST_RANK_SCAN && better) begin
         best_ff     <= idx_ff;
         best_act_ff <= cur_act;
         best_cnt_ff <= cur_cnt;
      end
      if (state_ff == car_pkg::ST_RANK_PICK && found_ff) begin
         rank_ff[slot_ff] <= car_pkg::rank_type'(best_ff);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == car_pkg::ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == car_pkg::ST_DONE && out_free) begin
         rsp_data_ff <= {1'b0, total_ff, ranked_n_ff,
                         rank_ff[3], rank_ff[2], rank_ff[1], rank_ff[0]};
      end
   end

   // checks
   `CAR_ASSERT_IMPL(a_count_bound, clock, reset, rsp_valid_ff,
      rsp_data_ff[22:20] <= 3'(car_pkg::FILL_SLOTS), "ranked count above slot count")
   `CAR_ASSERT_IMPL(a_last_slot_empty, clock, reset,
      rsp_valid_ff && rsp_data_ff[22:20] != 3'd4,
      rsp_data_ff[19:15] == car_pkg::EMPTY_RANK, "fourth slot filled with short ranking")
   `CAR_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_acc, !req_tready,
      "ready while an item is in work")
   `CAR_ASSERT_NEXT(a_total_step, clock, reset, 1'b1,
      total_ff == $past(total_ff) || total_ff == $past(total_ff) + 32'd1 ||
      total_ff == $past(total_ff) - 32'd1,
      "total moved by more than one")

endmodule

>>> dv/channel_activity_ranker_tb.sv
// self-checking testbench for the channel activity ranker: predictor, stimulus and result checks

// one result item as it sits on rsp_tdata, the last field (first) in the lowest bits
typedef struct packed {
   logic                fill;
   car_pkg::word_type   total;
   logic [2:0]          ranked;
   car_pkg::rank_type   fourth;
   car_pkg::rank_type   third;
   car_pkg::rank_type   second;
   car_pkg::rank_type   first;
} ranking_result;

// tracks channel state alongside the block and checks each ranking it returns
class activity_scoreboard;
   bit         rank_by_activity;
   bit [15:0]  factor;
   bit [15:0]  floor_level;
   bit [19:0]  idle_limit;
   bit [16:0]  drain_gap;

   car_pkg::act_type    act[car_pkg::CHANNELS];
   car_pkg::word_type   cnt[car_pkg::CHANNELS];
   car_pkg::word_type   seen_at[car_pkg::CHANNELS];
   car_pkg::word_type   total;
   car_pkg::word_type   any_seen_at;
   car_pkg::word_type   drained_at;

   ranking_result rankings_due[$];
   int         failures;

   function new();
      rank_by_activity = 1'b0;
      factor = 16'd65506;
      floor_level = 16'd131;
      idle_limit = 20'd20000;
      drain_gap = 17'd250;
      foreach (act[c]) begin
         act[c] = '0;
         cnt[c] = '0;
         seen_at[c] = '0;
      end
      total = '0;
      any_seen_at = '0;
      drained_at = '0;
      failures = 0;
   endfunction

   function void set_register(car_pkg::reg_idx_type idx, car_pkg::word_type value);
      unique case (idx)
         car_pkg::REG_DISPLAY_MODE: begin
            rank_by_activity = value[0];
         end
         car_pkg::REG_DECAY_FACTOR: begin
            factor = value[15:0];
         end
         car_pkg::REG_ACTIVITY_FLOOR: begin
            floor_level = value[15:0];
         end
         car_pkg::REG_IDLE_MS: begin
            idle_limit = value[19:0];
         end
         car_pkg::REG_DRAIN_MS: begin
            drain_gap = value[16:0];
         end
         default: begin
         end
      endcase
   endfunction

   // one unit of activity, saturating counts, fresh time stamps
   function void apply_event(logic [3:0] ch, car_pkg::word_type now);
      logic [24:0] sum;
      sum = {1'b0, act[ch]} + {1'b0, car_pkg::ACT_ONE};
      act[ch] = (sum > {1'b0, car_pkg::ACT_MAX}) ? car_pkg::ACT_MAX : sum[23:0];
      if (cnt[ch] != 32'hFFFF_FFFF) cnt[ch]++;
      seen_at[ch] = now;
      if (total != 32'hFFFF_FFFF) total++;
      any_seen_at = now;
   endfunction

   // elapsed times are taken modulo 2^32
   function void apply_drain(car_pkg::word_type now);
      if ((now - drained_at) < {15'd0, drain_gap}) return;
      drained_at = now;
      for (int c = 0; c < car_pkg::CHANNELS; c++) begin
         if (cnt[c] != 0 && (now - seen_at[c]) >= {12'd0, idle_limit}) cnt[c]--;
      end
      if (total != 0 && (now - any_seen_at) >= {12'd0, idle_limit}) total--;
   endfunction

   // truncating multiply, then clear anything under the floor
   function void apply_decay();
      logic [39:0] prod;
      for (int c = 0; c < car_pkg::CHANNELS; c++) begin
         prod = 40'(act[c]) * 40'(factor);
         act[c] = (prod[39:16] < {8'd0, floor_level}) ? '0 : prod[39:16];
      end
   endfunction

   // selection sort over the slots, lower channel wins ties
   function ranking_result rank_channels();
      ranking_result res;
      car_pkg::rank_type slot_ch[car_pkg::RANK_FIELDS];
      bit taken[car_pkg::CHANNELS];
      bit found;
      bit better;
      int best;
      car_pkg::act_type best_act;
      car_pkg::word_type best_cnt;
      int n;
      n = 0;
      foreach (taken[c]) taken[c] = 1'b0;
      foreach (slot_ch[s]) slot_ch[s] = car_pkg::EMPTY_RANK;
      for (int s = 0; s < car_pkg::FILL_SLOTS; s++) begin
         found = 1'b0;
         best = 0;
         best_act = '0;
         best_cnt = '0;
         for (int c = 0; c < car_pkg::CHANNELS; c++) begin
            if (taken[c]) continue;
            if (rank_by_activity) begin
               if (act[c] == 0) continue;
               better = !found || act[c] > best_act;
            end else begin
               if (cnt[c] == 0) continue;
               better = !found || act[c] > best_act ||
                        (act[c] == best_act && cnt[c] > best_cnt);
            end
            if (better) begin
               found = 1'b1;
               best = c;
               best_act = act[c];
               best_cnt = cnt[c];
            end
         end
         if (!found) break;
         taken[best] = 1'b1;
         slot_ch[s] = car_pkg::rank_type'(best);
         n++;
      end
      res.fill = 1'b0;
      res.total = total;
      res.ranked = 3'(n);
      res.first = slot_ch[0];
      res.second = slot_ch[1];
      res.third = slot_ch[2];
      res.fourth = slot_ch[3];
      return res;
   endfunction

   function void note_item(logic [1:0] kind, logic [3:0] ch, car_pkg::word_type now);
      if (kind == car_pkg::REQ_EVENT) apply_event(ch, now);
      else if (kind == car_pkg::REQ_DRAIN) apply_drain(now);
      else if (kind == car_pkg::REQ_DECAY) apply_decay();
      rankings_due.push_back(rank_channels());
   endfunction

   function void flag(string what, longint want_v, longint got_v);
      failures++;
      if (failures <= 10)
         $display("%0t: %s: expected %0d, got %0d", $time, what, want_v, got_v);
   endfunction

   function void check_result(logic [55:0] bits);
      ranking_result got;
      ranking_result want;
      got = bits;
      if (rankings_due.size() == 0) begin
         flag("result with no item outstanding", 0, longint'(got.total));
         return;
      end
      want = rankings_due.pop_front();
      if (got.first !== want.first)
         flag("rank_first", $signed(want.first), $signed(got.first));
      if (got.second !== want.second)
         flag("rank_second", $signed(want.second), $signed(got.second));
      if (got.third !== want.third)
         flag("rank_third", $signed(want.third), $signed(got.third));
      if (got.fourth !== want.fourth)
         flag("rank_fourth", $signed(want.fourth), $signed(got.fourth));
      if (got.ranked !== want.ranked)
         flag("ranked_count", longint'(want.ranked), longint'(got.ranked));
      if (got.total !== want.total)
         flag("total_events", longint'(want.total), longint'(got.total));
   endfunction

   function int pending();
      return rankings_due.size();
   endfunction
endclass

module channel_activity_ranker_tb;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam int WATCHDOG_LIMIT = 4000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // channel [3:0], now_ms [35:4], zero fill
   logic [1:0]  req_tuser = '0;   // req_type [1:0]
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;        // rank_first [4:0], rank_second [9:5],
                                  // rank_third [14:10], rank_fourth [19:15],
                                  // ranked_count [22:20], total_events [54:23]
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [4:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   activity_scoreboard ranking_board;
   car_pkg::word_type now_ms;
   bit       steady_flow = 1'b0;
   int       rsp_hold = 0;
   int       quiet_cycles = 0;

   channel_activity_ranker dut (.*);

   always #6 clock = ~clock;

   // mostly short pauses, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(30, 150);
   endfunction

   // result side back-pressure
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold <= rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady_flow && $urandom_range(0, 3) == 0) rsp_hold <= pick_gap();
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) ranking_board.check_result(rsp_tdata);
   end

   // watchdog on cycles with no item moving on either side
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // valid stays high between back-to-back items; it is lowered ahead of a gap and in wait_idle
   task automatic send_item(logic [1:0] kind, logic [3:0] ch, car_pkg::word_type now);
      int gap;
      gap = steady_flow ? 0 : pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {4'b0, now, ch};
      do @(posedge clock); while (!req_tready);
      ranking_board.note_item(kind, ch, now);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (ranking_board.pending() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_register(car_pkg::reg_idx_type idx, car_pkg::word_type value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      ranking_board.set_register(idx, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(bit mode, int dfactor, int afloor, int idle, int drain);
      wait_idle();
      write_register(car_pkg::REG_DISPLAY_MODE, car_pkg::word_type'(mode));
      write_register(car_pkg::REG_DECAY_FACTOR, car_pkg::word_type'(dfactor));
      write_register(car_pkg::REG_ACTIVITY_FLOOR, car_pkg::word_type'(afloor));
      write_register(car_pkg::REG_IDLE_MS, car_pkg::word_type'(idle));
      write_register(car_pkg::REG_DRAIN_MS, car_pkg::word_type'(drain));
   endtask

   // random traffic around one busy channel, time mostly creeping forward
   task automatic run_traffic(int items, int hot_pct, int event_pct, int drain_pct,
                              int step_max);
      logic [1:0] kind;
      logic [3:0] hot_ch;
      logic [3:0] ch;
      int r;
      hot_ch = 4'($urandom_range(0, 15));
      for (int i = 0; i < items; i++) begin
         r = $urandom_range(0, 99);
         if (r < event_pct) kind = car_pkg::REQ_EVENT;
         else if (r < event_pct + drain_pct) kind = car_pkg::REQ_DRAIN;
         else if (r < 99) kind = car_pkg::REQ_DECAY;
         else kind = REQ_UNUSED;
         ch = ($urandom_range(0, 99) < hot_pct) ? hot_ch : 4'($urandom_range(0, 15));
         if ($urandom_range(0, 99) < 2) now_ms = $urandom();
         else now_ms = now_ms + car_pkg::word_type'($urandom_range(0, step_max));
         send_item(kind, ch, now_ms);
      end
   endtask

   initial begin
      ranking_board = new();
      now_ms = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty ranking, extremes of time, drain timing and wrap
      send_item(car_pkg::REQ_DRAIN, 4'd0, 32'd0);
      send_item(car_pkg::REQ_DECAY, 4'd0, 32'd0);
      send_item(REQ_UNUSED, 4'd15, 32'hFFFF_FFFF);
      send_item(car_pkg::REQ_EVENT, 4'd0, 32'd100);
      send_item(car_pkg::REQ_EVENT, 4'd15, 32'd100);
      send_item(car_pkg::REQ_EVENT, 4'd15, 32'd120);
      send_item(car_pkg::REQ_EVENT, 4'd7, 32'd130);
      send_item(car_pkg::REQ_EVENT, 4'd3, 32'd140);
      send_item(car_pkg::REQ_DRAIN, 4'd0, 32'd300);
      send_item(car_pkg::REQ_DRAIN, 4'd0, 32'd400);
      send_item(car_pkg::REQ_DRAIN, 4'd0, 32'hFFFF_FFF0);
      send_item(car_pkg::REQ_EVENT, 4'd9, 32'd5);
      send_item(car_pkg::REQ_DECAY, 4'd0, 32'd5);
      send_item(car_pkg::REQ_DECAY, 4'd0, 32'd5);
      send_item(car_pkg::REQ_EVENT, 4'd15, 32'hFFFF_FFFF);

      // activity-only ranking, then wipe activity with a zero factor
      wait_idle();
      write_register(car_pkg::REG_DISPLAY_MODE, 32'd1);
      send_item(REQ_UNUSED, 4'd0, 32'd0);
      send_item(car_pkg::REQ_DECAY, 4'd0, 32'd0);
      wait_idle();
      write_register(car_pkg::REG_DECAY_FACTOR, 32'd0);
      write_register(car_pkg::REG_ACTIVITY_FLOOR, 32'd0);
      send_item(car_pkg::REQ_DECAY, 4'd0, 32'd0);
      wait_idle();
      write_register(car_pkg::REG_DISPLAY_MODE, 32'd0);
      send_item(car_pkg::REQ_EVENT, 4'd1, 32'd1000);
      send_item(car_pkg::REQ_DRAIN, 4'd0, 32'd1000);

      // near-default settings with a short idle time
      now_ms = $urandom();
      configure(1'b0, 65506, 131, 2000, 250);
      run_traffic(250, 40, 70, 20, 300);

      // widest registers, slow decay, one channel driven into saturation
      configure(1'b1, 65535, 0, 20'hFFFFF, 17'h1FFFF);
      steady_flow = 1'b1;
      run_traffic(350, 85, 90, 5, 200);
      steady_flow = 1'b0;

      // drain on every tick, high floor: many activity ties decided by count
      configure(1'b0, 32768, 65535, 0, 0);
      run_traffic(250, 30, 55, 35, 50);

      // random settings in both modes
      configure(1'b1, $urandom_range(0, 65535), $urandom_range(0, 4000),
                $urandom_range(0, 5000), $urandom_range(0, 600));
      run_traffic(250, 40, 60, 25, 400);
      configure(1'b0, $urandom_range(0, 65535), $urandom_range(0, 4000),
                $urandom_range(0, 5000), $urandom_range(0, 600));
      run_traffic(250, 40, 60, 25, 400);

      // fast fade with frequent draining
      configure(1'b1, 60000, 131, 500, 50);
      run_traffic(200, 50, 60, 25, 120);

      wait_idle();
      repeat (120) @(posedge clock);
      if (ranking_board.failures == 0 && ranking_board.pending() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
